// ===== hw/rtl/gtpu_enc_pkg.sv =====
// Shared types, codes and constants of the GTP-U encapsulator.
// No dependencies; every other file of the block refers to it by scoped names.
`default_nettype none

package gtpu_enc_pkg;

    // Largest IPv4 header the block is built for.
    localparam int MAX_HEADER_BYTES_DFLT = 60;

    // Counters and indexes inside a command cover bursts of up to 64 bytes.
    localparam int CMD_CNT_W = 6;

    // Entries in the command queue between front and back.
    localparam int QUEUE_DEPTH = 4;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SRC_ADDR = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DST_ADDR = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TEID     = 2'd2;

    // GTP-U header constants.
    localparam logic [7:0] GTP_FLAGS    = 8'h30;
    localparam logic [7:0] GTP_MSG_TYPE = 8'hFF;

    // Command kinds handed from front to back.
    localparam int KIND_W = 3;
    localparam logic [KIND_W-1:0] KIND_PASS        = 3'd0; // emit the byte itself
    localparam logic [KIND_W-1:0] KIND_STORE       = 3'd1; // hold a header byte, no output
    localparam logic [KIND_W-1:0] KIND_GTP         = 3'd2; // GTP-U header plus IP bytes 0..3
    localparam logic [KIND_W-1:0] KIND_FLUSH_FIRST = 3'd3; // early end within IP bytes 0..3
    localparam logic [KIND_W-1:0] KIND_HDR_END     = 3'd4; // rewritten header tail
    localparam logic [KIND_W-1:0] KIND_FLUSH_STORE = 3'd5; // early end within held bytes

    typedef struct packed {
        logic [7:0] data_byte;
        logic       packet_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_packet_last;
        logic       run_last;
        logic       truncated;
    } out_item_t;

    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [7:0]           data;
        logic                 last;
        logic                 trunc;
        logic [CMD_CNT_W-1:0] idx;
        logic [CMD_CNT_W-1:0] final_index;
        logic [31:0]          word;
        logic [15:0]          ck;
    } cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/gtpu_enc_queue.sv =====
// Short command queue that decouples the classifying front from the emitting back.
// Depends on gtpu_enc_pkg for the command type and the queue depth.
`default_nettype none

module gtpu_enc_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  gtpu_enc_pkg::cmd_t     wr_cmd,
    output logic                   full,
    input  wire logic              pop,
    output gtpu_enc_pkg::cmd_t     head,
    output logic                   empty
);

    localparam int PTR_W = $clog2(gtpu_enc_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(gtpu_enc_pkg::QUEUE_DEPTH + 1);

    gtpu_enc_pkg::cmd_t entry_reg [gtpu_enc_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(gtpu_enc_pkg::QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk) begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/gtpu_enc_front.sv =====
// Front end: accepts IPv4 bytes, tracks the header and the checksum, issues commands.
// Depends on gtpu_enc_pkg for the item and command types and the command kinds.
`default_nettype none

module gtpu_enc_front #(
    parameter int MAX_HEADER_BYTES = gtpu_enc_pkg::MAX_HEADER_BYTES_DFLT
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   pkt_valid,
    output logic                        pkt_stall,
    input  gtpu_enc_pkg::in_item_t      pkt_item,
    input  wire logic [31:0]            src_addr,
    input  wire logic [31:0]            dst_addr,
    input  wire logic                   q_full,
    output logic                        push,
    output gtpu_enc_pkg::cmd_t          cmd
);

    localparam int HLEN_W = $clog2(MAX_HEADER_BYTES + 1);

    function automatic logic [15:0] fold_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

    logic [15:0]       pos_reg;
    logic [HLEN_W-1:0] hlen_reg;
    logic [31:0]       fb_reg;
    logic [15:0]       acc_reg;
    logic [15:0]       src_sum_reg;
    logic [15:0]       dst_sum_reg;
    logic [15:0]       addr_sum_reg;

    logic              accept;
    logic              has_cmd;
    logic [7:0]        b;
    logic              last;
    logic [3:0]        ihl;
    logic [5:0]        hl_raw;
    logic [HLEN_W-1:0] hlen_eff;
    logic [15:0]       hlen16;
    logic              in_sum;
    logic [15:0]       word16;
    logic [15:0]       acc1;
    logic [15:0]       ck;
    logic [31:0]       fb_new;
    logic [31:0]       fb_aligned;

    assign b         = pkt_item.data_byte;
    assign last      = pkt_item.packet_last;
    assign pkt_stall = q_full;
    assign accept    = pkt_valid && !q_full;
    assign push      = accept && has_cmd;

    // Header length from IHL at the first byte, with small and oversized values bounded.
    always_comb begin
        ihl    = (b[3:0] < 4'd5) ? 4'd5 : b[3:0];
        hl_raw = {ihl, 2'b00};
        if (pos_reg == 16'd0)
        begin
            if (hl_raw > 6'(MAX_HEADER_BYTES))
            begin
                hlen_eff = HLEN_W'(MAX_HEADER_BYTES);
            end
            else
            begin
                hlen_eff = HLEN_W'(hl_raw);
            end
        end
        else
        begin
            hlen_eff = hlen_reg;
        end
    end

    assign hlen16 = 16'(hlen_eff);

    // Checksum field and both addresses are left out of the running sum.
    assign in_sum = (pos_reg < hlen16) && ((pos_reg < 16'd10) || (pos_reg >= 16'd20));
    assign word16 = pos_reg[0] ? {8'h00, b} : {b, 8'h00};
    assign acc1   = in_sum ? fold_add(acc_reg, word16) : acc_reg;
    assign ck     = ~fold_add(acc1, addr_sum_reg);
    assign fb_new = {fb_reg[23:0], b};

    always_comb begin
        unique case (pos_reg[1:0])
            2'd0:    fb_aligned = {fb_new[7:0], 24'd0};
            2'd1:    fb_aligned = {fb_new[15:0], 16'd0};
            2'd2:    fb_aligned = {fb_new[23:0], 8'd0};
            default: fb_aligned = fb_new;
        endcase
    end

    always_comb begin
        cmd             = '0;
        cmd.data        = b;
        cmd.last        = last;
        cmd.idx         = gtpu_enc_pkg::CMD_CNT_W'(pos_reg - 16'd10);
        cmd.ck          = ck;
        has_cmd         = 1'b1;
        priority if (pos_reg < 16'd4)
        begin
            if (last)
            begin
                cmd.kind        = gtpu_enc_pkg::KIND_FLUSH_FIRST;
                cmd.trunc       = 1'b1;
                cmd.final_index = gtpu_enc_pkg::CMD_CNT_W'(pos_reg[1:0]);
                cmd.word        = fb_aligned;
            end
            else if (pos_reg == 16'd3)
            begin
                cmd.kind        = gtpu_enc_pkg::KIND_GTP;
                cmd.final_index = gtpu_enc_pkg::CMD_CNT_W'(11);
                cmd.word        = fb_new;
            end
            else
            begin
                has_cmd = 1'b0;
            end
        end
        else if (pos_reg < 16'd10)
        begin
            cmd.kind  = gtpu_enc_pkg::KIND_PASS;
            cmd.trunc = last;
        end
        else if (pos_reg < hlen16)
        begin
            if (pos_reg == hlen16 - 16'd1)
            begin
                cmd.kind        = gtpu_enc_pkg::KIND_HDR_END;
                cmd.final_index = gtpu_enc_pkg::CMD_CNT_W'(hlen16 - 16'd11);
            end
            else if (last)
            begin
                cmd.kind        = gtpu_enc_pkg::KIND_FLUSH_STORE;
                cmd.trunc       = 1'b1;
                cmd.final_index = gtpu_enc_pkg::CMD_CNT_W'(pos_reg - 16'd10);
            end
            else
            begin
                cmd.kind = gtpu_enc_pkg::KIND_STORE;
            end
        end
        else
        begin
            cmd.kind = gtpu_enc_pkg::KIND_PASS;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            hlen_reg <= HLEN_W'(20);
            fb_reg   <= '0;
            acc_reg  <= '0;
        end
        else if (accept)
        begin
            if (last)
            begin
                pos_reg  <= '0;
                hlen_reg <= HLEN_W'(20);
                fb_reg   <= '0;
                acc_reg  <= '0;
            end
            else
            begin
                if (pos_reg != 16'hFFFF)
                begin
                    pos_reg <= pos_reg + 16'd1;
                end
                hlen_reg <= hlen_eff;
                if (pos_reg < 16'd4)
                begin
                    fb_reg <= fb_new;
                end
                acc_reg <= acc1;
            end
        end
    end

    // The address contribution to the checksum is summed ahead of time; the user must
    // change the addresses only while no packet is in flight; nothing here enforces it.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            src_sum_reg  <= '0;
            dst_sum_reg  <= '0;
            addr_sum_reg <= '0;
        end
        else
        begin
            src_sum_reg  <= fold_add(src_addr[31:16], src_addr[15:0]);
            dst_sum_reg  <= fold_add(dst_addr[31:16], dst_addr[15:0]);
            addr_sum_reg <= fold_add(src_sum_reg, dst_sum_reg);
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/gtpu_enc_back.sv =====
// Back end: carries out queued commands, holds header bytes and drives the output register.
// Depends on gtpu_enc_pkg for the command and output types and the command kinds.
`default_nettype none

module gtpu_enc_back #(
    parameter int MAX_HEADER_BYTES = gtpu_enc_pkg::MAX_HEADER_BYTES_DFLT
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   q_empty,
    input  gtpu_enc_pkg::cmd_t          q_head,
    output logic                        q_pop,
    input  wire logic [31:0]            src_addr,
    input  wire logic [31:0]            dst_addr,
    input  wire logic [31:0]            teid,
    output logic                        gtp_valid,
    input  wire logic                   gtp_stall,
    output gtpu_enc_pkg::out_item_t     gtp_item
);

    localparam int DEPTH = MAX_HEADER_BYTES - 10;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CW    = gtpu_enc_pkg::CMD_CNT_W;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    function automatic logic [7:0] byte_sel(input logic [31:0] w, input logic [1:0] k);
        logic [7:0] r;
        unique case (k)
            2'd0:    r = w[31:24];
            2'd1:    r = w[23:16];
            2'd2:    r = w[15:8];
            default: r = w[7:0];
        endcase
        return r;
    endfunction

    logic [7:0]              store_mem [DEPTH];
    logic [7:0]              rdata_reg;
    logic                    state_reg;
    logic                    state_next;
    logic [CW-1:0]           cnt_reg;
    logic [CW-1:0]           cnt_next;
    gtpu_enc_pkg::cmd_t      cmd_reg;
    logic                    out_valid_reg;
    gtpu_enc_pkg::out_item_t out_item_reg;

    logic                    out_free;
    logic                    emit;
    logic                    done;
    logic                    wr_en;
    logic [IDX_W-1:0]        wr_idx;
    logic [IDX_W-1:0]        rd_idx;
    logic [1:0]              k_addr;
    logic [7:0]              out_byte;

    assign out_free = !out_valid_reg || !gtp_stall;
    assign emit     = (state_reg == ST_RUN) && out_free;
    assign done     = emit && (cnt_reg == cmd_reg.final_index);
    assign q_pop    = !q_empty && ((state_reg == ST_IDLE) || done);

    assign wr_en  = q_pop && ((q_head.kind == gtpu_enc_pkg::KIND_STORE)
                           || (q_head.kind == gtpu_enc_pkg::KIND_HDR_END)
                           || (q_head.kind == gtpu_enc_pkg::KIND_FLUSH_STORE));
    assign wr_idx = q_head.idx[IDX_W-1:0];

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        if (q_pop)
        begin
            cnt_next   = '0;
            state_next = (q_head.kind == gtpu_enc_pkg::KIND_STORE) ? ST_IDLE : ST_RUN;
        end
        else if (done)
        begin
            state_next = ST_IDLE;
        end
        else if (emit)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
    end

    // The read address follows the counter's next value, so the held byte for the
    // current count is already in the read register when it is emitted.
    assign rd_idx = (cnt_next < CW'(DEPTH)) ? cnt_next[IDX_W-1:0] : '0;

    always_ff @(posedge clk) begin
        if (wr_en)
        begin
            store_mem[wr_idx] <= q_head.data;
        end
        if (wr_en && (wr_idx == rd_idx))
        begin
            rdata_reg <= q_head.data;
        end
        else
        begin
            rdata_reg <= store_mem[rd_idx];
        end
    end

    assign k_addr = cnt_reg[1:0] - 2'd2;

    always_comb begin
        out_byte = cmd_reg.data;
        unique case (cmd_reg.kind)
            gtpu_enc_pkg::KIND_GTP:
            begin
                if (cnt_reg == CW'(0))
                begin
                    out_byte = gtpu_enc_pkg::GTP_FLAGS;
                end
                else if (cnt_reg == CW'(1))
                begin
                    out_byte = gtpu_enc_pkg::GTP_MSG_TYPE;
                end
                else if ((cnt_reg >= CW'(4)) && (cnt_reg < CW'(8)))
                begin
                    out_byte = byte_sel(teid, cnt_reg[1:0]);
                end
                else
                begin
                    out_byte = byte_sel(cmd_reg.word, cnt_reg[1:0]);
                end
            end
            gtpu_enc_pkg::KIND_FLUSH_FIRST:
            begin
                out_byte = byte_sel(cmd_reg.word, cnt_reg[1:0]);
            end
            gtpu_enc_pkg::KIND_HDR_END:
            begin
                if (cnt_reg == CW'(0))
                begin
                    out_byte = cmd_reg.ck[15:8];
                end
                else if (cnt_reg == CW'(1))
                begin
                    out_byte = cmd_reg.ck[7:0];
                end
                else if (cnt_reg < CW'(6))
                begin
                    out_byte = byte_sel(src_addr, k_addr);
                end
                else if (cnt_reg < CW'(10))
                begin
                    out_byte = byte_sel(dst_addr, k_addr);
                end
                else
                begin
                    out_byte = rdata_reg;
                end
            end
            gtpu_enc_pkg::KIND_FLUSH_STORE:
            begin
                out_byte = rdata_reg;
            end
            default:
            begin
                out_byte = cmd_reg.data;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (out_free)
            begin
                out_valid_reg <= emit;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (q_pop)
        begin
            cmd_reg <= q_head;
        end
        if (emit)
        begin
            out_item_reg.out_byte        <= out_byte;
            out_item_reg.out_packet_last <= done && cmd_reg.last;
            out_item_reg.run_last        <= done;
            out_item_reg.truncated       <= cmd_reg.trunc;
        end
    end

    assign gtp_valid = out_valid_reg;
    assign gtp_item  = out_item_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/gtpu_encap_ip_rewrite.sv =====
// GTP-U encapsulator with IPv4 address rewrite. A pass-through byte passes the command
// queue, the back end's command register and the output register; such bytes stream at
// one per cycle while the output is not stalled. The 12-byte GTP-U burst is sent at IP
// byte 3. The input stalls while the 4-entry command queue is full. Reset clears the
// configuration to zero and all packet state; the header store holds no meaningful
// data until written and gets no clearing pass.
`default_nettype none

module gtpu_encap_ip_rewrite #(
    parameter int MAX_HEADER_BYTES = gtpu_enc_pkg::MAX_HEADER_BYTES_DFLT
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 pkt_valid,
    output logic                                      pkt_stall,
    input  gtpu_enc_pkg::in_item_t                    pkt_item,
    output logic                                      gtp_valid,
    input  wire logic                                 gtp_stall,
    output gtpu_enc_pkg::out_item_t                   gtp_item,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [gtpu_enc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [31:0]                          cfg_data
);

    logic [31:0]        src_addr_reg;
    logic [31:0]        dst_addr_reg;
    logic [31:0]        teid_reg;

    logic               q_full;
    logic               q_empty;
    logic               q_push;
    logic               q_pop;
    gtpu_enc_pkg::cmd_t q_wr_cmd;
    gtpu_enc_pkg::cmd_t q_head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            src_addr_reg <= '0;
            dst_addr_reg <= '0;
            teid_reg     <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                gtpu_enc_pkg::CFG_SRC_ADDR: src_addr_reg <= cfg_data;
                gtpu_enc_pkg::CFG_DST_ADDR: dst_addr_reg <= cfg_data;
                gtpu_enc_pkg::CFG_TEID:     teid_reg     <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    gtpu_enc_front #(
        .MAX_HEADER_BYTES(MAX_HEADER_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .pkt_valid (pkt_valid),
        .pkt_stall (pkt_stall),
        .pkt_item  (pkt_item),
        .src_addr  (src_addr_reg),
        .dst_addr  (dst_addr_reg),
        .q_full    (q_full),
        .push      (q_push),
        .cmd       (q_wr_cmd)
    );

    gtpu_enc_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .wr_cmd (q_wr_cmd),
        .full   (q_full),
        .pop    (q_pop),
        .head   (q_head),
        .empty  (q_empty)
    );

    gtpu_enc_back #(
        .MAX_HEADER_BYTES(MAX_HEADER_BYTES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .src_addr  (src_addr_reg),
        .dst_addr  (dst_addr_reg),
        .teid      (teid_reg),
        .gtp_valid (gtp_valid),
        .gtp_stall (gtp_stall),
        .gtp_item  (gtp_item)
    );

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench for the GTP-U encapsulator with IPv4 address rewrite.
// Refers directly only to gtpu_enc_pkg and gtpu_encap_ip_rewrite. It drives packets byte by byte,
// predicts every output transaction and compares them in order.
`default_nettype none

module tb;

    localparam int MAX_HDR = gtpu_enc_pkg::MAX_HEADER_BYTES_DFLT;

    // One row of the directed table. Where want_typed is set, want holds the single
    // result written out by hand; otherwise the predictor supplies the results.
    typedef struct packed {
        logic [7:0]              data;
        logic                    last;
        logic                    want_typed;
        gtpu_enc_pkg::out_item_t want;
    } stim_row_t;

    localparam int N_DIRECTED = 22;
    localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        // A one-byte packet with IHL zero: flushed as it is and flagged truncated.
        '{8'h00, 1'b1, 1'b1, gtpu_enc_pkg::out_item_t'{8'h00, 1'b1, 1'b1, 1'b1}},
        // Largest IHL, ending on IP byte 3: the four held bytes leave with no GTP header.
        '{8'h4F, 1'b0, 1'b0, gtpu_enc_pkg::out_item_t'(0)},
        '{8'h12, 1'b0, 1'b0, gtpu_enc_pkg::out_item_t'(0)},
        '{8'h34, 1'b0, 1'b0, gtpu_enc_pkg::out_item_t'(0)},
        '{8'h56, 1'b1, 1'b0, gtpu_enc_pkg::out_item_t'(0)},
        // Odd version nibble and an IHL below five, ending on IP byte 4.
        '{8'hC3, 1'b0, 1'b0, gtpu_enc_pkg::out_item_t'(0)},
        '{8'h00, 1'b0, 1'b0, gtpu_enc_pkg::out_item_t'(0)},
        '{8'h00, 1'b0, 1'b0, gtpu_enc_pkg::out_item_t'(0)},
        '{8'h30, 1'b0, 1'b0, gtpu_enc_pkg::out_item_t'(0)},
        '{8'hAB, 1'b1, 1'b1, gtpu_enc_pkg::out_item_t'{8'hAB, 1'b1, 1'b1, 1'b1}},
        // Plain header that ends two bytes into the held part.
        '{8'h45, 1'b0, 1'b0, gtpu_enc_pkg::out_item_t'(0)},
        '{8'h00, 1'b0, 1'b0, gtpu_enc_pkg::out_item_t'(0)},
        '{8'h00, 1'b0, 1'b0, gtpu_enc_pkg::out_item_t'(0)},
        '{8'h14, 1'b0, 1'b0, gtpu_enc_pkg::out_item_t'(0)},
        '{8'h12, 1'b0, 1'b1, gtpu_enc_pkg::out_item_t'{8'h12, 1'b0, 1'b1, 1'b0}},
        '{8'h34, 1'b0, 1'b1, gtpu_enc_pkg::out_item_t'{8'h34, 1'b0, 1'b1, 1'b0}},
        '{8'h40, 1'b0, 1'b1, gtpu_enc_pkg::out_item_t'{8'h40, 1'b0, 1'b1, 1'b0}},
        '{8'h00, 1'b0, 1'b1, gtpu_enc_pkg::out_item_t'{8'h00, 1'b0, 1'b1, 1'b0}},
        '{8'hFF, 1'b0, 1'b1, gtpu_enc_pkg::out_item_t'{8'hFF, 1'b0, 1'b1, 1'b0}},
        '{8'h11, 1'b0, 1'b1, gtpu_enc_pkg::out_item_t'{8'h11, 1'b0, 1'b1, 1'b0}},
        '{8'h00, 1'b0, 1'b0, gtpu_enc_pkg::out_item_t'(0)},
        '{8'h00, 1'b1, 1'b0, gtpu_enc_pkg::out_item_t'(0)}
    };

    logic                                 clk;
    logic                                 rst_n;
    logic                                 pkt_valid;
    logic                                 pkt_stall;
    gtpu_enc_pkg::in_item_t               pkt_item;
    logic                                 gtp_valid;
    logic                                 gtp_stall;
    gtpu_enc_pkg::out_item_t              gtp_item;
    logic                                 cfg_valid;
    logic                                 cfg_ready;
    logic [gtpu_enc_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [31:0]                          cfg_data;

    gtpu_encap_ip_rewrite DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .pkt_valid (pkt_valid),
        .pkt_stall (pkt_stall),
        .pkt_item  (pkt_item),
        .gtp_valid (gtp_valid),
        .gtp_stall (gtp_stall),
        .gtp_item  (gtp_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Encapsulator state as the testbench sees it.
    logic [31:0] src_addr  = '0;
    logic [31:0] dst_addr  = '0;
    logic [31:0] teid      = '0;
    logic [7:0]  held_hdr [MAX_HDR-10];
    logic [15:0] ip_pos    = '0;
    logic [5:0]  ihl_bytes = 6'd20;
    logic [31:0] lead_word = '0;
    logic [19:0] csum_acc  = '0;

    gtpu_enc_pkg::out_item_t step_results [$];
    gtpu_enc_pkg::out_item_t gtp_expected [$];
    gtpu_enc_pkg::out_item_t due;

    // Driver hand-over to the monitor for the byte currently offered.
    logic                    cur_typed = 1'b0;
    gtpu_enc_pkg::out_item_t cur_want  = '0;

    int unsigned send_gap_pct = 0;
    int unsigned rx_stall_pct = 0;
    int unsigned pkt_taken    = 0;
    int unsigned cfg_writes   = 0;
    int unsigned packets_seen = 0;
    int unsigned results_seen = 0;
    int unsigned trunc_seen   = 0;
    int unsigned errors       = 0;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(negedge clk)
        gtp_stall = ($urandom_range(99) < rx_stall_pct);

    function automatic void add_word(logic [15:0] w);
        csum_acc = csum_acc + w;
        csum_acc = {4'h0, csum_acc[15:0]} + (csum_acc >> 16);
    endfunction

    // Works out every output transaction caused by one accepted input byte.
    function automatic void encap_step(logic [7:0] b, logic last);
        logic [7:0]              seq [$];
        logic [7:0]              v;
        logic [15:0]             ck;
        int unsigned             p;
        int unsigned             ihl;
        logic                    trunc;
        gtpu_enc_pkg::out_item_t r;
        trunc = 1'b0;
        p = ip_pos;
        step_results.delete();
        if (p == 0) begin
            ihl = b[3:0];
            if (ihl < 5)
                ihl = 5;
            ihl_bytes = (ihl * 4 > MAX_HDR) ? 6'(MAX_HDR) : 6'(ihl * 4);
        end
        if (p < ihl_bytes && (p < 10 || p >= 20))
            add_word(p[0] ? {8'h00, b} : {b, 8'h00});

        if (p < 4) begin
            lead_word = {lead_word[23:0], b};
            if (last) begin
                for (int k = p; k >= 0; k--)
                    seq.push_back(lead_word[8*k +: 8]);
                trunc = 1'b1;
            end else if (p == 3) begin
                seq.push_back(gtpu_enc_pkg::GTP_FLAGS);
                seq.push_back(gtpu_enc_pkg::GTP_MSG_TYPE);
                seq.push_back(lead_word[15:8]);
                seq.push_back(lead_word[7:0]);
                for (int k = 3; k >= 0; k--)
                    seq.push_back(teid[8*k +: 8]);
                for (int k = 3; k >= 0; k--)
                    seq.push_back(lead_word[8*k +: 8]);
            end
        end else if (p < 10) begin
            seq.push_back(b);
            trunc = last;
        end else if (p < ihl_bytes) begin
            held_hdr[p-10] = b;
            if (p == ihl_bytes - 1) begin
                add_word(src_addr[31:16]);
                add_word(src_addr[15:0]);
                add_word(dst_addr[31:16]);
                add_word(dst_addr[15:0]);
                ck = ~csum_acc[15:0];
                for (int j = 10; j < ihl_bytes; j++) begin
                    if (j == 10)
                        v = ck[15:8];
                    else if (j == 11)
                        v = ck[7:0];
                    else if (j < 16)
                        v = src_addr[8*(15-j) +: 8];
                    else if (j < 20)
                        v = dst_addr[8*(19-j) +: 8];
                    else
                        v = held_hdr[j-10];
                    seq.push_back(v);
                end
            end else if (last) begin
                for (int j = 0; j <= p - 10; j++)
                    seq.push_back(held_hdr[j]);
                trunc = 1'b1;
            end
        end else begin
            seq.push_back(b);
        end

        foreach (seq[i]) begin
            r.out_byte        = seq[i];
            r.run_last        = (i == seq.size() - 1);
            r.out_packet_last = last && r.run_last;
            r.truncated       = trunc;
            step_results.push_back(r);
        end

        if (last) begin
            ip_pos    = '0;
            ihl_bytes = 6'd20;
            lead_word = '0;
            csum_acc  = '0;
        end else if (ip_pos != 16'hFFFF) begin
            ip_pos = ip_pos + 16'd1;
        end
    endfunction

    // Configuration writes, accepted input bytes and output transactions, all at the
    // rising edge so that the driver only ever sees settled counts at the falling edge.
    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    gtpu_enc_pkg::CFG_SRC_ADDR: src_addr = cfg_data;
                    gtpu_enc_pkg::CFG_DST_ADDR: dst_addr = cfg_data;
                    gtpu_enc_pkg::CFG_TEID:     teid     = cfg_data;
                    default:      ;
                endcase
                cfg_writes++;
            end
            if (pkt_valid && !pkt_stall) begin
                encap_step(pkt_item.data_byte, pkt_item.packet_last);
                if (cur_typed)
                    gtp_expected.push_back(cur_want);
                else
                    foreach (step_results[i])
                        gtp_expected.push_back(step_results[i]);
                if (pkt_item.packet_last)
                    packets_seen++;
                pkt_taken++;
            end
            if (gtp_valid && !gtp_stall) begin
                results_seen++;
                if (gtp_item.truncated)
                    trunc_seen++;
                if (gtp_expected.size() == 0) begin
                    $error("unexpected output transaction: out_byte %02h", gtp_item.out_byte);
                    errors++;
                end else begin
                    due = gtp_expected.pop_front();
                    if (gtp_item.out_byte !== due.out_byte) begin
                        $error("out_byte: expected %02h, got %02h",
                               due.out_byte, gtp_item.out_byte);
                        errors++;
                    end
                    if (gtp_item.out_packet_last !== due.out_packet_last) begin
                        $error("out_packet_last: expected %0b, got %0b",
                               due.out_packet_last, gtp_item.out_packet_last);
                        errors++;
                    end
                    if (gtp_item.run_last !== due.run_last) begin
                        $error("run_last: expected %0b, got %0b",
                               due.run_last, gtp_item.run_last);
                        errors++;
                    end
                    if (gtp_item.truncated !== due.truncated) begin
                        $error("truncated: expected %0b, got %0b",
                               due.truncated, gtp_item.truncated);
                        errors++;
                    end
                end
            end
        end
    end

    task automatic write_reg(logic [gtpu_enc_pkg::CFG_INDEX_W-1:0] idx, logic [31:0] val);
        int unsigned n0;
        n0 = cfg_writes;
        cfg_index = idx;
        cfg_data  = val;
        cfg_valid = 1'b1;
        while (cfg_writes == n0)
            @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_addresses(logic [31:0] s, logic [31:0] d, logic [31:0] t);
        write_reg(gtpu_enc_pkg::CFG_SRC_ADDR, s);
        write_reg(gtpu_enc_pkg::CFG_DST_ADDR, d);
        write_reg(gtpu_enc_pkg::CFG_TEID, t);
    endtask

    // Offers one byte and returns at the falling edge after its transaction.
    task automatic send_byte(logic [7:0] b, logic last, logic typed,
                             gtpu_enc_pkg::out_item_t want);
        int unsigned n0;
        while ($urandom_range(99) < send_gap_pct) begin
            pkt_valid = 1'b0;
            @(negedge clk);
        end
        n0 = pkt_taken;
        cur_typed = typed;
        cur_want  = want;
        pkt_item  = '{data_byte: b, packet_last: last};
        pkt_valid = 1'b1;
        while (pkt_taken == n0)
            @(negedge clk);
    endtask

    task automatic wait_drained(int unsigned settle);
        pkt_valid = 1'b0;
        while (gtp_expected.size() != 0)
            @(negedge clk);
        repeat (settle) @(negedge clk);
    endtask

    // Mostly well-formed packets with random content, some cut short inside the
    // header, and a few runts of one to four bytes. No packet is longer than room.
    task automatic send_random_packet(int unsigned room);
        int unsigned mix;
        int unsigned ihl;
        int unsigned hl;
        int unsigned n;
        logic [7:0]  b0;
        logic [7:0]  bt;
        mix = $urandom_range(99);
        ihl = ($urandom_range(3) == 0) ? $urandom_range(15) : 5;
        hl  = (ihl < 5 ? 5 : ihl) * 4;
        b0  = {($urandom_range(4) == 0) ? 4'($urandom) : 4'h4, 4'(ihl)};
        if (mix < 65)
            n = hl + $urandom_range(6);
        else if (mix < 85)
            n = 1 + $urandom_range(hl - 2);
        else
            n = 1 + $urandom_range(3);
        if (n > room)
            n = room;
        for (int i = 0; i < n; i++) begin
            if (i == 0)
                bt = b0;
            else if (i == 2 && mix < 65)
                bt = n[15:8];
            else if (i == 3 && mix < 65)
                bt = n[7:0];
            else
                bt = 8'($urandom);
            send_byte(bt, i == n - 1, 1'b0, '0);
        end
    endtask

    task automatic random_traffic(int unsigned n_items, bit pause_midway);
        int unsigned start;
        bit          paused;
        start  = pkt_taken;
        paused = 1'b0;
        while (pkt_taken - start < n_items) begin
            send_random_packet(n_items - (pkt_taken - start));
            if (pause_midway && !paused && pkt_taken - start >= n_items / 2) begin
                wait_drained(0);
                paused = 1'b1;
            end
        end
    endtask

    initial begin
        rst_n     = 1'b0;
        pkt_valid = 1'b0;
        pkt_item  = '0;
        cfg_valid = 1'b0;
        cfg_index = gtpu_enc_pkg::CFG_SRC_ADDR;
        cfg_data  = '0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed rows run with the configuration left at its reset value.
        foreach (DIRECTED_ROWS[i])
            send_byte(DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].last,
                      DIRECTED_ROWS[i].want_typed, DIRECTED_ROWS[i].want);
        wait_drained(20);

        set_addresses(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        random_traffic(47, 1'b0);
        wait_drained(20);

        set_addresses($urandom, $urandom, $urandom);
        send_gap_pct = 57;
        random_traffic(47, 1'b1);
        wait_drained(20);

        set_addresses('0, '0, '0);
        send_gap_pct = 0;
        rx_stall_pct = 57;
        random_traffic(47, 1'b0);
        wait_drained(20);

        set_addresses($urandom, 32'hFFFF_FFFF, $urandom);
        send_gap_pct = 35;
        rx_stall_pct = 35;
        random_traffic(47, 1'b1);
        wait_drained(20);

        $display("Sent %0d packets (%0d bytes): directed cases, then four idle and stall phases",
                 packets_seen, pkt_taken);
        $display("Checked %0d output transactions, %0d of them truncated; %0d register writes",
                 results_seen, trunc_seen, cfg_writes);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
